### rtl/wav_stream_parser_mono_mix_assert.svh
// Assertion macros used by the WAV stream parser top level.
`ifndef WAV_STREAM_PARSER_MONO_MIX_ASSERT_SVH
`define WAV_STREAM_PARSER_MONO_MIX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wsp_pkg.sv
// Shared types, codes and constants of the WAV stream parser.
package wsp_pkg;

    // Depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Little-endian tag words, first file byte in the low byte.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Core size of the fmt chunk and the only accepted sample width.
    localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
    localparam logic [15:0] PCM_BITS       = 16'd16;
    localparam logic [15:0] STEREO         = 16'd2;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
    localparam logic [2:0] ERR_NO_FMT    = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;
    localparam logic [2:0] ERR_WIDTH     = 3'd5;
    localparam logic [2:0] ERR_SHORT_FMT = 3'd6;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic               final_res;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic [15:0]        sample_bits;
        logic [31:0]        payload_bytes;
        logic [2:0]         error_code;
    } out_t;

    // Queue entry: a result, plus the right sample when a stereo mix is pending.
    typedef struct packed {
        out_t               item;
        logic               mix;
        logic signed [15:0] right;
    } work_t;

    // Queue status seen by the top level and the output stage.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/wsp_front.sv
// Byte parser: walks the RIFF chunks and classifies every byte into queue entries.
module wsp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  wsp_pkg::in_t   item,
    output logic           res_valid,
    output wsp_pkg::work_t res
);

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_CTAG,
        PH_CSIZE,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [3:0]         fbi_reg, fbi_next;
    logic [31:0]        tag_reg, tag_next;
    logic [31:0]        len_reg, len_next;
    logic [32:0]        skip_reg, skip_next;
    logic               fmt_seen_reg, fmt_seen_next;
    logic [15:0]        channels_reg, channels_next;
    logic [31:0]        rate_reg, rate_next;
    logic [15:0]        bits_reg, bits_next;
    logic [31:0]        data_left_reg, data_left_next;
    logic [7:0]         low_reg, low_next;
    logic [15:0]        left_reg, left_next;
    logic [1:0]         frame_reg, frame_next;

    logic [31:0] tag_shifted;
    logic [31:0] len_shifted;
    logic [15:0] raw_word;
    logic        eof;

    assign tag_shifted = {item.file_byte, tag_reg[31:8]};
    assign len_shifted = {item.file_byte, len_reg[31:8]};
    assign raw_word    = {item.file_byte, low_reg};
    assign eof         = item.end_of_file;

    // Builds a final error entry.
    function automatic wsp_pkg::work_t make_error(input logic [2:0] code);
        wsp_pkg::work_t w;
        w = '0;
        w.item.kind       = wsp_pkg::KIND_ERROR;
        w.item.final_res  = 1'b1;
        w.item.error_code = code;
        return w;
    endfunction

    // Next-state logic of the parser.
    always_comb
    begin
        phase_next     = phase_reg;
        fbi_next       = fbi_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        skip_next      = skip_reg;
        fmt_seen_next  = fmt_seen_reg;
        channels_next  = channels_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        data_left_next = data_left_reg;
        low_next       = low_reg;
        left_next      = left_reg;
        frame_next     = frame_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (take)
        begin
            if (item.cmd == wsp_pkg::CMD_RESTART)
            begin
                phase_next     = PH_RIFF;
                fbi_next       = '0;
                tag_next       = '0;
                len_next       = '0;
                skip_next      = '0;
                fmt_seen_next  = 1'b0;
                channels_next  = '0;
                rate_next      = '0;
                bits_next      = '0;
                data_left_next = '0;
                low_next       = '0;
                left_next      = '0;
                frame_next     = '0;
            end
            else
            begin
                case (phase_reg)
                    // Four-byte tags and the RIFF size field.
                    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG:
                    begin
                        tag_next = tag_shifted;
                        fbi_next = fbi_reg + 4'd1;
                        if (fbi_reg == 4'd3)
                        begin
                            fbi_next = '0;
                            case (phase_reg)
                                PH_RIFF:
                                begin
                                    if (tag_shifted != wsp_pkg::TAG_RIFF)
                                    begin
                                        res_valid  = 1'b1;
                                        res        = make_error(wsp_pkg::ERR_NO_RIFF);
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RSIZE;
                                    end
                                end
                                PH_RSIZE: phase_next = PH_WAVE;
                                PH_WAVE:
                                begin
                                    if (tag_shifted != wsp_pkg::TAG_WAVE)
                                    begin
                                        res_valid  = 1'b1;
                                        res        = make_error(wsp_pkg::ERR_NO_WAVE);
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_CTAG;
                                    end
                                end
                                default: phase_next = PH_CSIZE;
                            endcase
                        end
                    end

                    // Chunk length, then dispatch on the chunk tag.
                    PH_CSIZE:
                    begin
                        len_next = len_shifted;
                        fbi_next = fbi_reg + 4'd1;
                        if (fbi_reg == 4'd3)
                        begin
                            fbi_next = '0;
                            if (tag_reg == wsp_pkg::TAG_FMT)
                            begin
                                if (len_shifted < wsp_pkg::FMT_CORE_BYTES)
                                begin
                                    res_valid  = 1'b1;
                                    res        = make_error(wsp_pkg::ERR_SHORT_FMT);
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    channels_next = '0;
                                    rate_next     = '0;
                                    bits_next     = '0;
                                    phase_next    = PH_FMT;
                                end
                            end
                            else if (tag_reg == wsp_pkg::TAG_DATA)
                            begin
                                if (!fmt_seen_reg)
                                begin
                                    res_valid  = 1'b1;
                                    res        = make_error(wsp_pkg::ERR_NO_FMT);
                                    phase_next = PH_DONE;
                                end
                                else if (bits_reg != wsp_pkg::PCM_BITS)
                                begin
                                    res_valid  = 1'b1;
                                    res        = make_error(wsp_pkg::ERR_WIDTH);
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    data_left_next          = len_shifted;
                                    frame_next              = '0;
                                    res_valid               = 1'b1;
                                    res.item.kind           = wsp_pkg::KIND_HEADER;
                                    res.item.channel_count  = channels_reg;
                                    res.item.rate_hz        = rate_reg;
                                    res.item.sample_bits    = bits_reg;
                                    res.item.payload_bytes  = len_shifted;
                                    res.item.final_res      = (len_shifted == '0) || eof;
                                    phase_next = ((len_shifted == '0) || eof) ? PH_DONE
                                                                              : PH_DATA;
                                end
                            end
                            else
                            begin
                                // Unknown chunk: skip it and its pad byte.
                                skip_next  = {1'b0, len_shifted} + {32'd0, len_shifted[0]};
                                phase_next = (len_shifted == '0) ? PH_CTAG : PH_SKIP;
                            end
                        end
                    end

                    // Core bytes of the fmt chunk.
                    PH_FMT:
                    begin
                        case (fbi_reg)
                            4'd2:    channels_next[7:0]  = item.file_byte;
                            4'd3:    channels_next[15:8] = item.file_byte;
                            4'd4:    rate_next[7:0]      = item.file_byte;
                            4'd5:    rate_next[15:8]     = item.file_byte;
                            4'd6:    rate_next[23:16]    = item.file_byte;
                            4'd7:    rate_next[31:24]    = item.file_byte;
                            4'd14:   bits_next[7:0]      = item.file_byte;
                            4'd15:   bits_next[15:8]     = item.file_byte;
                            default: ;
                        endcase
                        fbi_next = fbi_reg + 4'd1;
                        if (fbi_reg == 4'd15)
                        begin
                            fbi_next      = '0;
                            fmt_seen_next = 1'b1;
                            skip_next     = {1'b0, len_reg - wsp_pkg::FMT_CORE_BYTES}
                                            + {32'd0, len_reg[0]};
                            phase_next    = ((len_reg == wsp_pkg::FMT_CORE_BYTES))
                                            ? PH_CTAG : PH_SKIP;
                        end
                    end

                    // Bytes of a skipped chunk.
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 33'd1;
                        if (skip_reg == 33'd1)
                        begin
                            phase_next = PH_CTAG;
                        end
                    end

                    // Sample bytes of the data chunk.
                    PH_DATA:
                    begin
                        data_left_next = data_left_reg - 32'd1;
                        case (frame_reg)
                            2'd0, 2'd2:
                            begin
                                low_next   = item.file_byte;
                                frame_next = frame_reg + 2'd1;
                            end
                            2'd1:
                            begin
                                if (channels_reg == wsp_pkg::STEREO)
                                begin
                                    left_next  = raw_word;
                                    frame_next = 2'd2;
                                end
                                else
                                begin
                                    res_valid       = 1'b1;
                                    res.item.kind   = wsp_pkg::KIND_SAMPLE;
                                    res.item.sample = raw_word;
                                    frame_next      = '0;
                                end
                            end
                            default:
                            begin
                                res_valid       = 1'b1;
                                res.item.kind   = wsp_pkg::KIND_SAMPLE;
                                res.item.sample = left_reg;
                                res.mix         = 1'b1;
                                res.right       = raw_word;
                                frame_next      = '0;
                            end
                        endcase
                        if ((data_left_reg == 32'd1) || eof)
                        begin
                            phase_next = PH_DONE;
                            if (res_valid)
                            begin
                                res.item.final_res = 1'b1;
                            end
                            else
                            begin
                                res_valid          = 1'b1;
                                res.item.kind      = wsp_pkg::KIND_END;
                                res.item.final_res = 1'b1;
                            end
                        end
                    end

                    default: phase_next = PH_DONE;
                endcase

                // End of file before the data chunk was reached.
                if (!res_valid && eof && (phase_reg != PH_DATA) && (phase_reg != PH_DONE))
                begin
                    res_valid  = 1'b1;
                    res        = make_error(wsp_pkg::ERR_EARLY_END);
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            fbi_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            skip_reg      <= '0;
            fmt_seen_reg  <= 1'b0;
            channels_reg  <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            data_left_reg <= '0;
            low_reg       <= '0;
            left_reg      <= '0;
            frame_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fbi_reg       <= fbi_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            skip_reg      <= skip_next;
            fmt_seen_reg  <= fmt_seen_next;
            channels_reg  <= channels_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            data_left_reg <= data_left_next;
            low_reg       <= low_next;
            left_reg      <= left_next;
            frame_reg     <= frame_next;
        end
    end

endmodule

### rtl/wsp_queue.sv
// Short register queue between the parser and the output stage.
module wsp_queue #(
    parameter int DEPTH = wsp_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  wsp_pkg::work_t         wr_data,
    input  logic                   rd_en,
    output wsp_pkg::work_t         rd_data,
    output wsp_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wsp_pkg::work_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign rd_data      = entries_reg[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/wsp_back.sv
// Output stage: finishes the stereo mix and holds the result beat for the consumer.
module wsp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wsp_pkg::work_t         head,
    input  wsp_pkg::queue_status_t q_status,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output wsp_pkg::out_t          result
);

    logic               valid_reg, valid_next;
    wsp_pkg::out_t      result_reg, result_next;
    logic signed [16:0] sum;
    logic signed [16:0] sum_adj;

    // Left plus right, biased by one when negative so the halving truncates toward zero.
    assign sum     = 17'(head.item.sample) + 17'(head.right);
    assign sum_adj = sum + {16'd0, sum[16]};

    assign q_pop  = !q_status.empty && (!valid_reg || pop);
    assign empty  = !valid_reg;
    assign result = result_reg;

    // Output register load.
    always_comb
    begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (q_pop)
        begin
            valid_next  = 1'b1;
            result_next = head.item;
            if (head.mix)
            begin
                result_next.sample = sum_adj[16:1];
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

### rtl/wav_stream_parser_mono_mix.sv
// WAV stream parser with stereo-to-mono mix. One file byte is taken per clock cycle while
// full is low; the parser itself never holds a byte back. Each byte yields at most one
// result, which passes through a queue of QUEUE_DEPTH entries and then an output register
// before it reaches the result ports. full rises only when the queue holds QUEUE_DEPTH
// results that the consumer has not taken. A restart beat clears the parser but keeps
// results already queued. There is no clearing pass after reset.
`include "wav_stream_parser_mono_mix_assert.svh"

module wav_stream_parser_mono_mix #(
    parameter int QUEUE_DEPTH = wsp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  wsp_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output wsp_pkg::out_t result
);

    logic                   take;
    logic                   front_valid;
    wsp_pkg::work_t         front_res;
    wsp_pkg::work_t         q_head;
    wsp_pkg::queue_status_t q_status;
    logic                   q_pop;

    assign full = q_status.full;
    assign take = push && !q_status.full;

    // Byte parser.
    wsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (front_valid),
        .res       (front_res)
    );

    // Queue between parser and output stage.
    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_res),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .status  (q_status)
    );

    // Mix and output register.
    wsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    // Design checks.
    `WSP_ASSERT_NEXT(a_drain, empty && !q_status.empty, !empty, "queued result not moved out")
    `WSP_ASSERT_SAME(a_err_final, !empty && (result.kind == wsp_pkg::KIND_ERROR),
        result.final_res && (result.error_code != wsp_pkg::ERR_NONE), "error beat malformed")
    `WSP_ASSERT_SAME(a_end_final, !empty && (result.kind == wsp_pkg::KIND_END),
        result.final_res && (result.sample == '0), "end beat malformed")
    `WSP_ASSERT_SAME(a_smp_clean, !empty && (result.kind == wsp_pkg::KIND_SAMPLE),
        (result.error_code == wsp_pkg::ERR_NONE) && (result.payload_bytes == '0),
        "sample beat carries header or error fields")

endmodule
